### rtl/core/weighted_multi_pattern_scorer_macros.svh
// Assertion shorthands shared by the scorer modules
`ifndef WEIGHTED_MULTI_PATTERN_SCORER_MACROS_SVH
`define WEIGHTED_MULTI_PATTERN_SCORER_MACROS_SVH
// Check a consequence in the same cycle
`define WMPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check a consequence in the next cycle
`define WMPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/core/wmps_pkg.sv
package wmps_pkg;
	localparam int MAX_NODES   = 1024;
	localparam int MAX_LETTERS = 26;
	localparam int NODE_W      = $clog2(MAX_NODES);
	localparam int CNT_W       = NODE_W + 1;
	localparam int LET_W       = 5;
	localparam int TT_DEPTH    = MAX_NODES * MAX_LETTERS;
	localparam int TT_AW       = $clog2(TT_DEPTH);
	localparam int PAIR_DEPTH  = MAX_LETTERS * MAX_LETTERS;
	localparam int PAIR_AW     = $clog2(PAIR_DEPTH);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam logic [7:0] LETTER_BASE = 8'd97;
	localparam logic [5:0] PREV_EMPTY  = 6'd63;
	localparam logic [5:0] PREV_BAD    = 6'd32;

	typedef enum logic [2:0] {
		FN_PSYM  = 3'd0,
		FN_PEND  = 3'd1,
		FN_BUILD = 3'd2,
		FN_PAIR  = 3'd3,
		FN_TEXT  = 3'd4,
		FN_CLEAR = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EARLY = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PS_EV, ST_CLR, ST_PE_WR, ST_BR_RD, ST_BR_EV, ST_BQ_CHK,
		ST_BV, ST_BLK, ST_BW1, ST_BW2, ST_BS_RD, ST_BS_RD2, ST_BS_EV,
		ST_TX_NW, ST_TX_ADD, ST_DONE
	} bstate_t;

	// classified item as held in the queue
	typedef struct packed {
		logic [2:0]       func;
		logic [LET_W-1:0] letter;
		logic             letter_ok;
		logic [LET_W-1:0] second;
		logic             pair_ok;
		logic [63:0]      weight;
		logic             last;
	} qitem_t;

	typedef struct packed {
		logic pop;
		logic boot;
	} bk_ctl_t;

	function automatic logic [TT_AW-1:0] tt_addr(input logic [NODE_W-1:0] n,
			input logic [LET_W-1:0] c);
		return TT_AW'(n) * TT_AW'(MAX_LETTERS) + TT_AW'(c);
	endfunction

	function automatic logic [PAIR_AW-1:0] pair_addr(input logic [LET_W-1:0] a,
			input logic [LET_W-1:0] b);
		return PAIR_AW'(a) * PAIR_AW'(MAX_LETTERS) + PAIR_AW'(b);
	endfunction
endpackage

### rtl/core/wmps_if.sv
interface wmps_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [7:0]  symbol;
	logic [4:0]  second_symbol;
	logic signed [63:0] weight;
	logic        last;
	modport source(output valid, func, symbol, second_symbol, weight, last, input ready);
	modport sink(input valid, func, symbol, second_symbol, weight, last, output ready);
endinterface

interface wmps_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [63:0] total;
	logic        invalid;
	logic [1:0]  status;
	logic        done_res;
	modport source(output valid, total, invalid, status, done_res, input ready);
	modport sink(input valid, total, invalid, status, done_res, output ready);
endinterface

interface wmps_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] alphabet_size;
	modport source(output valid, alphabet_size, input ready);
	modport sink(input valid, alphabet_size, output ready);
endinterface

### rtl/core/weighted_multi_pattern_scorer.sv
// Text symbol: the transition table and pair weight reads are chained into the node
// weight read; the next item is started only once the result has been loaded.
// Pattern symbol: a new node empties its 26-entry row.
// Build: each root letter, then each queued node's fail link, weights and letters.
// Reset is asynchronous, active low; a pass empties the root row after reset
// and after a clear, and no transaction is accepted during the reset pass.
module weighted_multi_pattern_scorer (
	input  logic       clk,
	input  logic       arst_n,
	wmps_req_if.sink   req,
	wmps_rsp_if.source rsp,
	wmps_cfg_if.sink   cfg
);
	import wmps_pkg::*;

	logic [LET_W-1:0] alph_q, k;
	qitem_t           head;
	logic             avail;
	bk_ctl_t          ctl;

	// alphabet size register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) alph_q <= LET_W'(MAX_LETTERS);
		else if (cfg.valid) alph_q <= cfg.alphabet_size;
	end

	// clamp into one to the letter count
	assign k = (alph_q == '0) ? LET_W'(1) :
		(alph_q > LET_W'(MAX_LETTERS)) ? LET_W'(MAX_LETTERS) : alph_q;

	wmps_front u_front (
		.clk(clk), .arst_n(arst_n), .k(k), .req(req), .ctl(ctl), .head(head), .avail(avail)
	);

	wmps_back u_back (
		.clk(clk), .arst_n(arst_n), .k(k), .head(head), .avail(avail), .ctl(ctl), .rsp(rsp)
	);
endmodule

### rtl/core/wmps_front.sv
`include "weighted_multi_pattern_scorer_macros.svh"
module wmps_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [wmps_pkg::LET_W-1:0] k,
	wmps_req_if.sink                  req,
	input  wmps_pkg::bk_ctl_t         ctl,
	output wmps_pkg::qitem_t          head,
	output logic                      avail
);
	import wmps_pkg::*;

	qitem_t            q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic [7:0]        off;
	logic              push, pop;
	qitem_t            item;

	// classify the incoming transaction
	always_comb begin
		off            = req.symbol - LETTER_BASE;
		item.func      = req.func;
		item.letter    = off[LET_W-1:0];
		item.letter_ok = (req.symbol >= LETTER_BASE) && (off < 8'(k));
		item.second    = req.second_symbol;
		item.pair_ok   = req.second_symbol < k;
		item.weight    = req.weight;
		item.last      = req.last;
	end

	assign req.ready = (cnt_q != (QPTR_W+1)'(QDEPTH)) && !ctl.boot;
	assign push      = req.valid && req.ready;
	assign pop       = ctl.pop;
	assign head      = q_mem[rd_ptr_q];
	assign avail     = cnt_q != '0;

	// store classified items
	always_ff @(posedge clk) begin
		if (push) q_mem[wr_ptr_q] <= item;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

	`WMPS_ASSERT_NOW(a_q_cnt, 1'b1, cnt_q <= (QPTR_W+1)'(QDEPTH), "queue overfilled")
	`WMPS_ASSERT_NOW(a_q_pop, pop, cnt_q != '0, "pop from empty queue")
	`WMPS_ASSERT_NEXT(a_q_full, cnt_q == (QPTR_W+1)'(QDEPTH) && !pop, cnt_q == (QPTR_W+1)'(QDEPTH), "full queue lost an entry")
endmodule

### rtl/core/wmps_back.sv
`include "weighted_multi_pattern_scorer_macros.svh"
module wmps_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [wmps_pkg::LET_W-1:0] k,
	input  wmps_pkg::qitem_t          head,
	input  logic                      avail,
	output wmps_pkg::bk_ctl_t         ctl,
	wmps_rsp_if.source                rsp
);
	import wmps_pkg::*;

	// memories
	logic [CNT_W-1:0]  tt_mem [TT_DEPTH];
	logic [NODE_W-1:0] fl_mem [MAX_NODES];
	logic [63:0]       nw_mem [MAX_NODES];
	logic [63:0]       pw_mem [PAIR_DEPTH];
	logic [NODE_W-1:0] bq_mem [MAX_NODES];

	logic              tt_we, fl_we, nw_we, pw_we, bq_we;
	logic [TT_AW-1:0]  tt_wa, tt_ra;
	logic [CNT_W-1:0]  tt_wd, tt_rd_q;
	logic [NODE_W-1:0] fl_wa, fl_ra, fl_wd, fl_rd_q;
	logic [NODE_W-1:0] nw_wa, nw_ra;
	logic [63:0]       nw_wd, nw_rd_q;
	logic [PAIR_AW-1:0] pw_wa, pw_ra;
	logic [63:0]       pw_wd, pw_rd_q;
	logic [NODE_W-1:0] bq_wa, bq_ra, bq_wd, bq_rd_q;

	// control state
	bstate_t           state_q, state_d;
	qitem_t            cur_q, cur_d;
	logic [CNT_W-1:0]  node_count_q, node_count_d;
	logic [NODE_W-1:0] cursor_q, cursor_d, scan_q, scan_d;
	logic [5:0]        prev_q, prev_d;
	logic [63:0]       total_q, total_d, nwa_q, nwa_d;
	logic              inv_q, inv_d, built_q, built_d, boot_q, boot_d, pok_q, pok_d;
	logic [CNT_W-1:0]  head_q, head_d, tail_q, tail_d, slot_q, slot_d;
	logic [LET_W-1:0]  cnt_q, cnt_d;
	logic [NODE_W-1:0] v_q, v_d, lk_q, lk_d, row_q, row_d;
	status_t           status_q, status_d;
	logic              out_valid_q, out_load;
	logic [63:0]       out_total_q;
	logic              out_inv_q, out_done_q;
	logic [1:0]        out_status_q;
	logic [63:0]       res_total;
	logic              res_inv, res_done;

	logic [CNT_W-1:0]  e_m1, slot_m1;
	logic [NODE_W-1:0] g;
	logic              has_prev, prev_ok;
	logic [LET_W-1:0]  k_m1;

	assign e_m1    = tt_rd_q - CNT_W'(1);
	assign slot_m1 = slot_q - CNT_W'(1);
	assign g       = (tt_rd_q != '0) ? e_m1[NODE_W-1:0] : '0;
	assign k_m1    = k - LET_W'(1);

	// next state and memory controls
	always_comb begin
		state_d = state_q; cur_d = cur_q; node_count_d = node_count_q;
		cursor_d = cursor_q; scan_d = scan_q; prev_d = prev_q; total_d = total_q;
		nwa_d = nwa_q; inv_d = inv_q; built_d = built_q; boot_d = boot_q; pok_d = pok_q;
		head_d = head_q; tail_d = tail_q; slot_d = slot_q; cnt_d = cnt_q;
		v_d = v_q; lk_d = lk_q; row_d = row_q; status_d = status_q;
		tt_we = 1'b0; tt_wa = '0; tt_wd = '0; tt_ra = '0;
		fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = '0;
		nw_we = 1'b0; nw_wa = '0; nw_wd = '0; nw_ra = '0;
		pw_we = 1'b0; pw_wa = '0; pw_wd = '0; pw_ra = '0;
		bq_we = 1'b0; bq_wa = '0; bq_wd = '0; bq_ra = '0;
		ctl.pop = 1'b0; ctl.boot = boot_q;
		out_load = 1'b0; res_total = '0; res_inv = 1'b0; res_done = 1'b0;
		has_prev = prev_q != PREV_EMPTY;
		prev_ok  = prev_q < 6'(MAX_LETTERS);
		case (state_q)
			ST_IDLE: begin
				if (avail) begin
					ctl.pop  = 1'b1;
					cur_d    = head;
					status_d = STS_OK;
					state_d  = ST_DONE;
					case (head.func)
						FN_PSYM: begin
							if (!built_q && head.letter_ok) begin
								tt_ra   = tt_addr(cursor_q, head.letter);
								state_d = ST_PS_EV;
							end
						end
						FN_PEND: begin
							if (!built_q) begin
								nw_ra   = cursor_q;
								state_d = ST_PE_WR;
							end
						end
						FN_BUILD: begin
							if (!built_q) begin
								cnt_d   = '0;
								head_d  = '0;
								tail_d  = '0;
								state_d = ST_BR_RD;
							end
						end
						FN_PAIR: begin
							if (head.letter_ok && head.pair_ok) begin
								pw_we = 1'b1;
								pw_wa = pair_addr(head.letter, head.second);
								pw_wd = head.weight;
							end
						end
						FN_TEXT: begin
							if (!built_q) begin
								status_d = STS_EARLY;
							end else begin
								if (has_prev && (!prev_ok || !head.letter_ok)) inv_d = 1'b1;
								if (head.letter_ok) begin
									tt_ra   = tt_addr(scan_q, head.letter);
									pw_ra   = prev_ok ? pair_addr(prev_q[LET_W-1:0], head.letter) : '0;
									pok_d   = prev_ok;
									state_d = ST_TX_NW;
								end else begin
									prev_d = PREV_BAD;
								end
							end
						end
						FN_CLEAR: begin
							node_count_d = CNT_W'(1);
							cursor_d = '0; built_d = 1'b0;
							scan_d = '0; prev_d = PREV_EMPTY; total_d = '0; inv_d = 1'b0;
							row_d = '0; cnt_d = '0;
							state_d = ST_CLR;
						end
						default: ;
					endcase
				end
			end
			// walk or extend the trie
			ST_PS_EV: begin
				state_d = ST_DONE;
				if (tt_rd_q != '0) begin
					cursor_d = e_m1[NODE_W-1:0];
				end else if (node_count_q >= CNT_W'(MAX_NODES)) begin
					status_d = STS_FULL;
				end else begin
					tt_we = 1'b1;
					tt_wa = tt_addr(cursor_q, cur_q.letter);
					tt_wd = node_count_q + CNT_W'(1);
					cursor_d = node_count_q[NODE_W-1:0];
					row_d    = node_count_q[NODE_W-1:0];
					node_count_d = node_count_q + CNT_W'(1);
					cnt_d    = '0;
					state_d  = ST_CLR;
				end
			end
			// empty one trie row and its weight
			ST_CLR: begin
				tt_we = 1'b1;
				tt_wa = tt_addr(row_q, cnt_q);
				tt_wd = '0;
				if (cnt_q == '0) begin
					nw_we = 1'b1;
					nw_wa = row_q;
					nw_wd = '0;
				end
				cnt_d = cnt_q + LET_W'(1);
				if (cnt_q == LET_W'(MAX_LETTERS - 1)) begin
					if (boot_q) begin
						boot_d  = 1'b0;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_PE_WR: begin
				nw_we    = 1'b1;
				nw_wa    = cursor_q;
				nw_wd    = nw_rd_q + cur_q.weight;
				cursor_d = '0;
				state_d  = ST_DONE;
			end
			// root letters of the build pass
			ST_BR_RD: begin
				tt_ra   = TT_AW'(cnt_q);
				state_d = ST_BR_EV;
			end
			ST_BR_EV: begin
				if (tt_rd_q != '0) begin
					fl_we = 1'b1;
					fl_wa = e_m1[NODE_W-1:0];
					fl_wd = '0;
					if (tail_q < CNT_W'(MAX_NODES)) begin
						bq_we  = 1'b1;
						bq_wa  = tail_q[NODE_W-1:0];
						bq_wd  = e_m1[NODE_W-1:0];
						tail_d = tail_q + CNT_W'(1);
					end
				end else begin
					tt_we = 1'b1;
					tt_wa = TT_AW'(cnt_q);
					tt_wd = CNT_W'(1);
				end
				cnt_d   = cnt_q + LET_W'(1);
				state_d = (cnt_q == k_m1) ? ST_BQ_CHK : ST_BR_RD;
			end
			// breadth-first queue
			ST_BQ_CHK: begin
				if (head_q < tail_q) begin
					bq_ra   = head_q[NODE_W-1:0];
					head_d  = head_q + CNT_W'(1);
					state_d = ST_BV;
				end else begin
					built_d = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_BV: begin
				v_d     = bq_rd_q;
				fl_ra   = bq_rd_q;
				state_d = ST_BLK;
			end
			ST_BLK: begin
				lk_d    = fl_rd_q;
				nw_ra   = fl_rd_q;
				state_d = ST_BW1;
			end
			ST_BW1: begin
				nwa_d   = nw_rd_q;
				nw_ra   = v_q;
				state_d = ST_BW2;
			end
			ST_BW2: begin
				nw_we   = 1'b1;
				nw_wa   = v_q;
				nw_wd   = nw_rd_q + nwa_q;
				cnt_d   = '0;
				state_d = ST_BS_RD;
			end
			ST_BS_RD: begin
				tt_ra   = tt_addr(v_q, cnt_q);
				state_d = ST_BS_RD2;
			end
			ST_BS_RD2: begin
				slot_d  = tt_rd_q;
				tt_ra   = tt_addr(lk_q, cnt_q);
				state_d = ST_BS_EV;
			end
			ST_BS_EV: begin
				if (slot_q != '0) begin
					fl_we = 1'b1;
					fl_wa = slot_m1[NODE_W-1:0];
					fl_wd = g;
					if (tail_q < CNT_W'(MAX_NODES)) begin
						bq_we  = 1'b1;
						bq_wa  = tail_q[NODE_W-1:0];
						bq_wd  = slot_m1[NODE_W-1:0];
						tail_d = tail_q + CNT_W'(1);
					end
				end else begin
					tt_we = 1'b1;
					tt_wa = tt_addr(v_q, cnt_q);
					tt_wd = CNT_W'(g) + CNT_W'(1);
				end
				cnt_d   = cnt_q + LET_W'(1);
				state_d = (cnt_q == k_m1) ? ST_BQ_CHK : ST_BS_RD;
			end
			// text scan: transition and pair weight reads, then node weight
			ST_TX_NW: begin
				scan_d = g;
				nw_ra  = g;
				if (pok_q) total_d = total_q + pw_rd_q;
				prev_d  = {1'b0, cur_q.letter};
				state_d = ST_TX_ADD;
			end
			ST_TX_ADD: begin
				total_d = total_q + nw_rd_q;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (cur_q.func == FN_TEXT) begin
						res_total = total_q;
						res_inv   = inv_q;
						res_done  = cur_q.last;
						if (cur_q.last) begin
							scan_d = '0; prev_d = PREV_EMPTY; total_d = '0; inv_d = 1'b0;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (tt_we) tt_mem[tt_wa] <= tt_wd;
		tt_rd_q <= tt_mem[tt_ra];
	end
	always_ff @(posedge clk) begin
		if (fl_we) fl_mem[fl_wa] <= fl_wd;
		fl_rd_q <= fl_mem[fl_ra];
	end
	always_ff @(posedge clk) begin
		if (nw_we) nw_mem[nw_wa] <= nw_wd;
		nw_rd_q <= nw_mem[nw_ra];
	end
	always_ff @(posedge clk) begin
		if (pw_we) pw_mem[pw_wa] <= pw_wd;
		pw_rd_q <= pw_mem[pw_ra];
	end
	always_ff @(posedge clk) begin
		if (bq_we) bq_mem[bq_wa] <= bq_wd;
		bq_rd_q <= bq_mem[bq_ra];
	end

	// state register; reset starts with a pass that empties the root row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR; node_count_q <= CNT_W'(1); cursor_q <= '0; scan_q <= '0;
			prev_q <= PREV_EMPTY; total_q <= '0; inv_q <= 1'b0; built_q <= 1'b0;
			boot_q <= 1'b1; pok_q <= 1'b0; head_q <= '0; tail_q <= '0; cnt_q <= '0;
			row_q <= '0; status_q <= STS_OK;
		end else begin
			state_q <= state_d; node_count_q <= node_count_d; cursor_q <= cursor_d;
			scan_q <= scan_d; prev_q <= prev_d; total_q <= total_d; inv_q <= inv_d;
			built_q <= built_d; boot_q <= boot_d; pok_q <= pok_d; head_q <= head_d;
			tail_q <= tail_d; cnt_q <= cnt_d; row_q <= row_d; status_q <= status_d;
		end
	end

	// item and scratch registers
	always_ff @(posedge clk) begin
		cur_q <= cur_d; nwa_q <= nwa_d; slot_q <= slot_d; v_q <= v_d; lk_q <= lk_d;
	end

	// hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_total_q  <= res_total;
			out_inv_q    <= res_inv;
			out_done_q   <= res_done;
			out_status_q <= status_q;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.total    = out_total_q;
	assign rsp.invalid  = out_inv_q;
	assign rsp.status   = out_status_q;
	assign rsp.done_res = out_done_q;

	`WMPS_ASSERT_NOW(a_nodes, 1'b1, node_count_q != '0 && node_count_q <= CNT_W'(MAX_NODES), "node count out of range")
	`WMPS_ASSERT_NOW(a_bfs, 1'b1, head_q <= tail_q, "build queue head passed tail")
	`WMPS_ASSERT_NEXT(a_res_load, !out_valid_q && state_q != ST_DONE, !out_valid_q, "result raised outside completion")
endmodule
